/* sv/wvc_pkg.sv */
package wvc_pkg;

	localparam int CordicSteps = 14;
	localparam int StepW = $clog2(CordicSteps + 1);

	// CORDIC word: 33-bit offsets plus growth headroom
	localparam int CW = 36;
	localparam int ZW = 24;

	localparam logic signed [15:0] PiQ12 = 16'sd12868;
	localparam logic signed [16:0] TwoPiQ12 = 17'sd25736;
	localparam logic signed [15:0] HalfPiQ12 = 16'sd6434;
	localparam logic signed [ZW-1:0] PiQ20 = 24'sd3294198;
	localparam logic signed [15:0] OneQ12 = 16'sd4096;

	typedef enum logic [1:0] {
		CFG_MAX_SPEED = 2'd0,
		CFG_ACCEL = 2'd1,
		CFG_TURN = 2'd2,
		CFG_TOL = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_ITER,
		ST_SQUARE,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic iter;
		logic square;
		logic finish;
		logic [StepW-1:0] step;
	} dp_cmd_t;

	function automatic logic signed [ZW-1:0] atan_q20(input logic [StepW-1:0] i);
		logic signed [ZW-1:0] r;
		begin
			case (i)
				0: r = 24'sd823550;
				1: r = 24'sd486170;
				2: r = 24'sd256879;
				3: r = 24'sd130396;
				4: r = 24'sd65451;
				5: r = 24'sd32757;
				6: r = 24'sd16383;
				7: r = 24'sd8192;
				8: r = 24'sd4096;
				9: r = 24'sd2048;
				10: r = 24'sd1024;
				11: r = 24'sd512;
				12: r = 24'sd256;
				13: r = 24'sd128;
				14: r = 24'sd64;
				15: r = 24'sd32;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

/* sv/wvc_ctrl.sv */
module wvc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic out_busy,
	input logic out_fire,
	output logic in_ready,
	output logic out_load,
	output wvc_pkg::dp_cmd_t cmd
);
	import wvc_pkg::*;

	state_t state_q, state_d;
	logic [StepW-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ITER) step_q <= step_q + 1'b1;
			else step_q <= '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_ITER;
			ST_ITER: if (step_q == StepW'(CordicSteps - 1)) state_d = ST_SQUARE;
			ST_SQUARE: state_d = ST_FINISH;
			ST_FINISH: state_d = ST_OUT;
			ST_OUT: if (!out_busy || out_fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.load = in_fire;
		cmd.setup = (state_q == ST_SETUP);
		cmd.iter = (state_q == ST_ITER);
		cmd.square = (state_q == ST_SQUARE);
		cmd.finish = (state_q == ST_FINISH);
		cmd.step = step_q;
		out_load = (state_q == ST_OUT) && (!out_busy || out_fire);
	end
endmodule

/* sv/wvc_dp.sv */
module wvc_dp (
	input logic clk,
	input logic arst_n,
	input wvc_pkg::dp_cmd_t cmd,
	input logic commit,
	input logic [14:0] max_speed,
	input logic [12:0] accel_step,
	input logic [14:0] max_turn_rate,
	input logic [30:0] goal_tolerance,
	input logic auto_mode,
	input logic turn_in_place,
	input logic signed [31:0] robot_x,
	input logic signed [31:0] robot_y,
	input logic signed [14:0] robot_heading,
	input logic signed [31:0] goal_x,
	input logic signed [31:0] goal_y,
	input logic signed [13:0] stick_speed,
	input logic signed [13:0] stick_turn,
	output logic signed [15:0] speed_res,
	output logic signed [15:0] turn_res,
	output logic goal_res
);
	import wvc_pkg::*;

	logic auto_q, tip_q;
	logic signed [14:0] head_q;
	logic signed [13:0] sspeed_q, sturn_q;
	logic signed [32:0] dx_q, dy_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic signed [15:0] cur_q;
	logic signed [28:0] prod_q;
	logic [63:0] sq_q;
	logic [61:0] tol2_q;
	logic near_q;
	logic signed [15:0] speed_q, turn_q;
	logic goal_q;

	logic signed [CW-1:0] xs, ys, dxe, dye;
	logic signed [ZW-1:0] zr;
	logic signed [16:0] ang, diff0, diff;
	logic signed [17:0] tgt, s1;
	logic signed [15:0] lim, tn, sp;
	logic zero_off;
	logic [32:0] adx, ady;

	assign dxe = CW'(dx_q);
	assign dye = CW'(dy_q);
	assign xs = x_q >>> cmd.step;
	assign ys = y_q >>> cmd.step;
	assign adx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
	assign ady = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
	assign zero_off = (dx_q == '0) && (dy_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			auto_q <= auto_mode;
			tip_q <= turn_in_place;
			head_q <= robot_heading;
			sspeed_q <= stick_speed;
			sturn_q <= stick_turn;
			dx_q <= 33'(goal_x) - 33'(robot_x);
			dy_q <= 33'(goal_y) - 33'(robot_y);
		end
		if (cmd.setup) begin
			// fold into the right half plane
			if (dx_q[32]) begin
				x_q <= -dxe;
				y_q <= -dye;
				z_q <= dy_q[32] ? -PiQ20 : PiQ20;
			end else begin
				x_q <= dxe;
				y_q <= dye;
				z_q <= '0;
			end
			prod_q <= $signed({1'b0, max_speed}) * sspeed_q;
			near_q <= (adx < {2'b0, goal_tolerance}) && (ady < {2'b0, goal_tolerance});
			tol2_q <= goal_tolerance * goal_tolerance;
		end
		if (cmd.iter) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q20(cmd.step);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q20(cmd.step);
			end
		end
		if (cmd.square) begin
			// 32x32 squares, only consulted when both under a 31-bit tolerance
			sq_q <= 64'(adx[31:0] * adx[31:0]) + 64'(ady[31:0] * ady[31:0]);
		end
		if (cmd.finish) begin
			speed_q <= sp;
			turn_q <= tn;
			goal_q <= auto_q && near_q && (sq_q < 64'(tol2_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cur_q <= '0;
		else if (commit) cur_q <= speed_q;
	end

	always_comb begin
		zr = z_q + ZW'(128);
		ang = zero_off ? '0 : 17'(zr >>> 8);
		diff0 = 17'(head_q) - ang;
		if (diff0 > 17'(PiQ12)) diff = diff0 - TwoPiQ12;
		else if (diff0 < -17'(PiQ12)) diff = diff0 + TwoPiQ12;
		else diff = diff0;
		lim = {1'b0, max_turn_rate};
		if (auto_q) tgt = {3'b0, max_speed};
		else tgt = 18'(prod_q + 29'sd2048 >>> 12);
		if (18'(cur_q) < tgt) s1 = 18'(cur_q) + 18'(accel_step);
		else if (18'(cur_q) > tgt) s1 = 18'(cur_q) - 18'(accel_step);
		else s1 = 18'(cur_q);
		if (s1 > 18'sd32767) sp = 16'sd32767;
		else if (s1 < -18'sd32768) sp = -16'sd32768;
		else sp = s1[15:0];
		if (auto_q) begin
			if (diff > 17'(lim)) tn = lim;
			else if (diff < -17'(lim)) tn = -lim;
			else tn = diff[15:0];
			if (!zero_off && (diff > 17'(HalfPiQ12) || diff < -17'(HalfPiQ12))) sp = '0;
			if (tip_q) begin
				sp = '0;
				tn = OneQ12;
			end
			if (near_q && (sq_q < 64'(tol2_q))) begin
				sp = '0;
				tn = '0;
			end
		end else begin
			if (sspeed_q == '0) sp = '0;
			tn = 16'(sturn_q);
		end
	end

	assign speed_res = speed_q;
	assign turn_res = turn_q;
	assign goal_res = goal_q;
endmodule

/* sv/waypoint_velocity_controller.sv */
// Waypoint velocity controller: one control tick in, one command out.
// s_axis: one item per tick, tdata packs the pose, goal, stick and mode fields
// (see port comment). m_axis: speed_cmd, turn_cmd and at_goal.
// cfg_we/cfg_index/cfg_data write max_speed (0), accel_step (1),
// max_turn_rate (2) and goal_tolerance (3); write only while idle.
// An accepted item passes through load, setup, one shared CORDIC vectoring
// step per cycle, squaring and final select before output valid. One item
// at a time: no new item is accepted until the previous one has been moved
// into the output register.
// The output register holds its item until taken; a finished item waits in
// the controller until the register frees, and s_axis_tready stays low.
// Reset restores register defaults and zeros the stored speed.
module waypoint_velocity_controller (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// auto_mode[0] turn_in_place[1] robot_x[33:2] robot_y[65:34] robot_heading[80:66]
	// goal_x[112:81] goal_y[144:113] stick_speed[158:145] stick_turn[172:159]
	input logic [175:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// speed_cmd[15:0] turn_cmd[31:16] at_goal[32]
	output logic [39:0] m_axis_tdata,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [30:0] cfg_data
);
	import wvc_pkg::*;

	logic [14:0] max_speed_q, turn_lim_q;
	logic [12:0] accel_q;
	logic [30:0] tol_q;
	logic in_fire, out_fire, out_load;
	dp_cmd_t cmd;
	logic signed [15:0] speed_res, turn_res;
	logic goal_res;
	logic [39:0] out_q;
	logic valid_q;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= 15'd4096;
			accel_q <= 13'd41;
			turn_lim_q <= 15'd3277;
			tol_q <= 31'd32768;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_SPEED: max_speed_q <= cfg_data[14:0];
				CFG_ACCEL: accel_q <= cfg_data[12:0];
				CFG_TURN: turn_lim_q <= cfg_data[14:0];
				CFG_TOL: tol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	wvc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_busy(valid_q),
		.out_fire(out_fire), .in_ready(s_axis_tready), .out_load(out_load), .cmd(cmd)
	);

	wvc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .commit(out_load),
		.max_speed(max_speed_q), .accel_step(accel_q), .max_turn_rate(turn_lim_q),
		.goal_tolerance(tol_q),
		.auto_mode(s_axis_tdata[0]), .turn_in_place(s_axis_tdata[1]),
		.robot_x(s_axis_tdata[33:2]), .robot_y(s_axis_tdata[65:34]),
		.robot_heading(s_axis_tdata[80:66]), .goal_x(s_axis_tdata[112:81]),
		.goal_y(s_axis_tdata[144:113]), .stick_speed(s_axis_tdata[158:145]),
		.stick_turn(s_axis_tdata[172:159]),
		.speed_res(speed_res), .turn_res(turn_res), .goal_res(goal_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (out_load) valid_q <= 1'b1;
		else if (out_fire) valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= {7'b0, goal_res, turn_res, speed_res};
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = out_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.iter |-> !s_axis_tready) else $error("input accepted mid-computation");
	a_load_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!valid_q || out_fire)) else $error("output overwritten");
	a_goal_auto: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[32]) |-> (m_axis_tdata[15:0] == 16'd0))
		else $error("at_goal with nonzero speed");
endmodule
